### rtl/dtg_pkg.sv
// Shared types, constants and helper functions of the DTMF tone generator.
// Used by dtg_ctrl, dtg_datapath and dtmf_tone_generator_unit; no dependencies.

package dtg_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = SAMPLE_BITS + 1;
    localparam int PHASE_BITS  = 32;
    localparam int FREQ_BITS   = 11;
    localparam int RATE_BITS   = 18;
    localparam int DUR_BITS    = 16;
    localparam int AMP_BITS    = 15;
    localparam int MUL_BITS    = 16;

    // Quarter-wave polynomial coefficients, Q15
    localparam logic [MUL_BITS-1:0] POLY_A = 16'd51472;
    localparam logic [MUL_BITS-1:0] POLY_B = 16'd21024;
    localparam logic [MUL_BITS-1:0] POLY_C = 16'd2320;

    localparam logic [RATE_BITS-1:0] RATE_RESET      = 18'd8000;
    localparam logic [DUR_BITS-1:0]  DURATION_RESET  = 16'd800;
    localparam logic [AMP_BITS-1:0]  LOW_AMP_RESET   = 15'd9234;
    localparam logic [AMP_BITS-1:0]  HIGH_AMP_RESET  = 15'd11626;

    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_SET_TONE = 1'b1;

    typedef enum logic [1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_DURATION    = 2'd1,
        REG_LOW_AMP     = 2'd2,
        REG_HIGH_AMP    = 2'd3
    } dtg_reg_idx_t;

    typedef enum logic [2:0] {
        MUL_ZZ  = 3'd0,
        MUL_CZ2 = 3'd1,
        MUL_TZ2 = 3'd2,
        MUL_TZ  = 3'd3,
        MUL_AMP = 3'd4
    } dtg_mul_op_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] digit;
    } dtg_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          tone_ending;
    } dtg_result_t;

    typedef struct packed {
        logic        load_key;
        logic        tick_start;
        logic        div_init;
        logic        div_step;
        logic        div_store;
        logic        sel_high;
        logic        sin_setup;
        logic        mul_en;
        dtg_mul_op_t mul_op;
        logic        finish;
    } dtg_cmd_t;

    typedef struct packed {
        logic key_valid;
        logic tone_on;
        logic out_free;
    } dtg_status_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic [1:0] col;
    } dtg_key_t;

    function automatic dtg_key_t decode_key(input logic [7:0] ch);
        dtg_key_t k;
        k.valid = 1'b1;
        k.row   = 2'd0;
        k.col   = 2'd0;
        unique case (ch) inside
            8'h31:        begin k.row = 2'd0; k.col = 2'd0; end  // '1'
            8'h32:        begin k.row = 2'd0; k.col = 2'd1; end  // '2'
            8'h33:        begin k.row = 2'd0; k.col = 2'd2; end  // '3'
            8'h41, 8'h61: begin k.row = 2'd0; k.col = 2'd3; end  // 'A'
            8'h34:        begin k.row = 2'd1; k.col = 2'd0; end  // '4'
            8'h35:        begin k.row = 2'd1; k.col = 2'd1; end  // '5'
            8'h36:        begin k.row = 2'd1; k.col = 2'd2; end  // '6'
            8'h42, 8'h62: begin k.row = 2'd1; k.col = 2'd3; end  // 'B'
            8'h37:        begin k.row = 2'd2; k.col = 2'd0; end  // '7'
            8'h38:        begin k.row = 2'd2; k.col = 2'd1; end  // '8'
            8'h39:        begin k.row = 2'd2; k.col = 2'd2; end  // '9'
            8'h43, 8'h63: begin k.row = 2'd2; k.col = 2'd3; end  // 'C'
            8'h2A:        begin k.row = 2'd3; k.col = 2'd0; end  // '*'
            8'h30:        begin k.row = 2'd3; k.col = 2'd1; end  // '0'
            8'h23:        begin k.row = 2'd3; k.col = 2'd2; end  // '#'
            8'h44, 8'h64: begin k.row = 2'd3; k.col = 2'd3; end  // 'D'
            default:      k.valid = 1'b0;
        endcase
        return k;
    endfunction

    function automatic logic [FREQ_BITS-1:0] low_freq(input logic [1:0] row);
        logic [FREQ_BITS-1:0] f;
        case (row)
            2'd0:    f = 11'd697;
            2'd1:    f = 11'd770;
            2'd2:    f = 11'd852;
            default: f = 11'd941;
        endcase
        return f;
    endfunction

    function automatic logic [FREQ_BITS-1:0] high_freq(input logic [1:0] col);
        logic [FREQ_BITS-1:0] f;
        case (col)
            2'd0:    f = 11'd1209;
            2'd1:    f = 11'd1336;
            2'd2:    f = 11'd1477;
            default: f = 11'd1633;
        endcase
        return f;
    endfunction

endpackage

### rtl/dtg_ctrl.sv
// Sequencer of the DTMF tone generator: takes input beats and steps the datapath.
// Depends on dtg_pkg.

module dtg_ctrl
    import dtg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        item_cmd,
    input  dtg_status_t status,
    output dtg_cmd_t    cmd
);

    localparam int CNT_BITS = $clog2(PHASE_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(PHASE_BITS - 1);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DIV_INIT  = 7'b0000010,
        S_DIV_RUN   = 7'b0000100,
        S_DIV_DONE  = 7'b0001000,
        S_SIN_SETUP = 7'b0010000,
        S_SIN_MUL   = 7'b0100000,
        S_FINISH    = 7'b1000000
    } dtg_state_t;

    dtg_state_t           state_reg, state_next;
    logic                 high_reg, high_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    dtg_mul_op_t          op_reg, op_next;

    always_comb
    begin
        state_next     = state_reg;
        high_next      = high_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        item_ready     = 1'b0;
        cmd            = '0;
        cmd.mul_op     = op_reg;
        cmd.sel_high   = high_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    high_next = 1'b0;
                    if (item_cmd == CMD_SET_TONE)
                    begin
                        cmd.load_key = 1'b1;
                        if (status.key_valid)
                            state_next = S_DIV_INIT;
                    end
                    else
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = status.tone_on ? S_SIN_SETUP : S_FINISH;
                    end
                end
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = S_DIV_DONE;
            end
            S_DIV_DONE:
            begin
                cmd.div_store = 1'b1;
                if (high_reg)
                    state_next = S_IDLE;
                else
                begin
                    high_next  = 1'b1;
                    state_next = S_DIV_INIT;
                end
            end
            S_SIN_SETUP:
            begin
                cmd.sin_setup = 1'b1;
                op_next       = MUL_ZZ;
                state_next    = S_SIN_MUL;
            end
            S_SIN_MUL:
            begin
                cmd.mul_en = 1'b1;
                case (op_reg)
                    MUL_ZZ:  op_next = MUL_CZ2;
                    MUL_CZ2: op_next = MUL_TZ2;
                    MUL_TZ2: op_next = MUL_TZ;
                    MUL_TZ:  op_next = MUL_AMP;
                    default:
                    begin
                        op_next = MUL_ZZ;
                        if (high_reg)
                            state_next = S_FINISH;
                        else
                        begin
                            high_next  = 1'b1;
                            state_next = S_SIN_SETUP;
                        end
                    end
                endcase
            end
            S_FINISH:
            begin
                // hold until the result register can take the beat
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            high_reg  <= 1'b0;
            cnt_reg   <= '0;
            op_reg    <= MUL_ZZ;
        end
        else
        begin
            state_reg <= state_next;
            high_reg  <= high_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
        end
    end

endmodule

### rtl/dtg_datapath.sv
// Datapath of the DTMF tone generator: radix-2 divider, shared sine multiplier,
// phase accumulators, tone counter and result register. Depends on dtg_pkg.

module dtg_datapath
    import dtg_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dtg_cmd_t             cmd,
    output dtg_status_t          status,
    input  logic [7:0]           digit,
    input  logic [RATE_BITS-1:0] sample_rate,
    input  logic [DUR_BITS-1:0]  duration,
    input  logic [AMP_BITS-1:0]  low_amp,
    input  logic [AMP_BITS-1:0]  high_amp,
    output dtg_result_t          result,
    output logic                 result_valid,
    input  logic                 result_ready
);

    localparam int ZPAD = 17 - SINE_ADDR_BITS;

    // Tone state
    logic                  tone_on_reg;
    logic [PHASE_BITS-1:0] low_inc_reg, high_inc_reg;
    logic [PHASE_BITS-1:0] low_phase_reg, high_phase_reg;
    logic [DUR_BITS-1:0]   count_reg;
    logic [1:0]            row_reg, col_reg;

    // Divider
    logic [RATE_BITS-1:0]  rem_reg;
    logic [PHASE_BITS-1:0] quo_reg;
    logic                  sat_reg;

    // Sine evaluation
    logic [MUL_BITS-1:0]       z_reg, z2_reg, t_reg;
    logic [AMP_BITS-1:0]       s_reg;
    logic                      neg_reg;
    logic signed [SUM_BITS-1:0] sum_reg;

    dtg_result_t result_reg;
    logic        result_valid_reg;

    dtg_key_t                    key;
    logic [FREQ_BITS-1:0]        freq;
    logic [RATE_BITS:0]          div_shift, div_diff;
    logic                        div_fits;
    logic [PHASE_BITS-1:0]       phase;
    logic [SINE_ADDR_BITS-1:0]   sine_addr;
    logic [1:0]                  quarter;
    logic [14:0]                 z_pos;
    logic [MUL_BITS-1:0]         z_set;
    logic [MUL_BITS-1:0]         mul_a, mul_b;
    logic [2*MUL_BITS-1:0]       product;
    logic [MUL_BITS-1:0]         prod_hi;
    logic [AMP_BITS-1:0]         amp;
    logic signed [SUM_BITS-1:0]  term;
    logic [SAMPLE_BITS-1:0]      sum_sat;
    logic [DUR_BITS-1:0]         count_inc;
    logic                        ending;
    logic                        out_free;

    assign key  = decode_key(digit);
    assign freq = cmd.sel_high ? high_freq(col_reg) : low_freq(row_reg);

    // One restoring step: bring down a zero bit
    assign div_shift = {rem_reg, 1'b0};
    assign div_fits  = div_shift >= {1'b0, sample_rate};
    assign div_diff  = div_shift - {1'b0, sample_rate};

    assign phase     = cmd.sel_high ? high_phase_reg : low_phase_reg;
    assign sine_addr = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign quarter   = sine_addr[SINE_ADDR_BITS-1 -: 2];
    assign z_pos     = {sine_addr[SINE_ADDR_BITS-3:0], {ZPAD{1'b0}}};
    // mirror in the second and fourth quarter
    assign z_set     = quarter[0] ? (16'h8000 - {1'b0, z_pos}) : {1'b0, z_pos};

    assign amp = cmd.sel_high ? high_amp : low_amp;

    always_comb
    begin
        case (cmd.mul_op)
            MUL_ZZ:  begin mul_a = z_reg;          mul_b = z_reg;        end
            MUL_CZ2: begin mul_a = POLY_C;         mul_b = z2_reg;       end
            MUL_TZ2: begin mul_a = t_reg;          mul_b = z2_reg;       end
            MUL_TZ:  begin mul_a = t_reg;          mul_b = z_reg;        end
            MUL_AMP: begin mul_a = {1'b0, s_reg};  mul_b = {1'b0, amp};  end
            default: begin mul_a = '0;             mul_b = '0;           end
        endcase
    end

    assign product = mul_a * mul_b;
    assign prod_hi = product[30:15];
    assign term    = neg_reg ? -SUM_BITS'(product[29:15]) : SUM_BITS'(product[29:15]);

    always_comb
    begin
        if (sum_reg[SUM_BITS-1] != sum_reg[SUM_BITS-2])
            sum_sat = sum_reg[SUM_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                          : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else
            sum_sat = sum_reg[SAMPLE_BITS-1:0];
    end

    assign count_inc = count_reg + 1'b1;
    assign ending    = tone_on_reg && (count_inc == duration);
    assign out_free  = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_on_reg      <= 1'b0;
            low_inc_reg      <= '0;
            high_inc_reg     <= '0;
            low_phase_reg    <= '0;
            high_phase_reg   <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_key)
            begin
                tone_on_reg <= key.valid;
                if (key.valid)
                    count_reg <= '0;
            end
            if (cmd.div_store)
            begin
                if (cmd.sel_high)
                    high_inc_reg <= sat_reg ? '1 : quo_reg;
                else
                    low_inc_reg  <= sat_reg ? '1 : quo_reg;
            end
            if (cmd.finish && tone_on_reg)
            begin
                low_phase_reg  <= low_phase_reg + low_inc_reg;
                high_phase_reg <= high_phase_reg + high_inc_reg;
                count_reg      <= count_inc;
                if (ending)
                    tone_on_reg <= 1'b0;
            end
            if (cmd.finish)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key && key.valid)
        begin
            row_reg <= key.row;
            col_reg <= key.col;
        end
        if (cmd.div_init)
        begin
            rem_reg <= RATE_BITS'(freq);
            quo_reg <= '0;
            // rate at or below the frequency (zero included) overflows 32 bits
            sat_reg <= sample_rate <= RATE_BITS'(freq);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_fits ? div_diff[RATE_BITS-1:0] : div_shift[RATE_BITS-1:0];
            quo_reg <= {quo_reg[PHASE_BITS-2:0], div_fits};
        end
        if (cmd.tick_start)
            sum_reg <= '0;
        if (cmd.sin_setup)
        begin
            z_reg   <= z_set;
            neg_reg <= quarter[1];
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_op)
                MUL_ZZ:  z2_reg  <= prod_hi;
                MUL_CZ2: t_reg   <= POLY_B - prod_hi;
                MUL_TZ2: t_reg   <= POLY_A - prod_hi;
                MUL_TZ:  s_reg   <= product[30] ? {AMP_BITS{1'b1}} : product[29:15];
                MUL_AMP: sum_reg <= sum_reg + term;
                default: ;
            endcase
        end
        if (cmd.finish)
        begin
            result_reg.sample      <= tone_on_reg ? sum_sat : '0;
            result_reg.tone_ending <= ending;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign status.key_valid = key.valid;
    assign status.tone_on   = tone_on_reg;
    assign status.out_free  = out_free;

endmodule

### rtl/dtmf_tone_generator_unit.sv
// Top level of the DTMF tone generator: APB register file, sequencer and datapath.
// Depends on dtg_pkg, dtg_ctrl and dtg_datapath.
//
//  channel   signals                               direction  beat
//  item      item_valid, item_ready, item          in         cmd, digit
//  result    result_valid, result_ready, result    out        sample, tone_ending
//  config    psel, penable, pwrite, paddr, pwdata  in         APB write, prdata read
//
// While a tone plays, a tick runs two sine
// evaluations of five steps each on the one shared 16x16 multiplier. A silent tick
// skips them, and an invalid set-tone is handled in idle. A valid set-tone runs
// two 32-step radix-2 divisions by the sample rate. Reset clears the tone state and
// loads the register defaults. A result that is not taken stalls only the next tick,
// at its last step; set-tone beats go on being accepted meanwhile.

module dtmf_tone_generator_unit
    import dtg_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  dtg_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output dtg_result_t result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [RATE_BITS-1:0] sample_rate_reg;
    logic [DUR_BITS-1:0]  duration_reg;
    logic [AMP_BITS-1:0]  low_amp_reg;
    logic [AMP_BITS-1:0]  high_amp_reg;
    logic                 cfg_write;
    dtg_reg_idx_t         reg_idx;

    dtg_cmd_t    dp_cmd;
    dtg_status_t dp_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = dtg_reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= RATE_RESET;
            duration_reg    <= DURATION_RESET;
            low_amp_reg     <= LOW_AMP_RESET;
            high_amp_reg    <= HIGH_AMP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_SAMPLE_RATE: sample_rate_reg <= pwdata[RATE_BITS-1:0];
                REG_DURATION:    duration_reg    <= pwdata[DUR_BITS-1:0];
                REG_LOW_AMP:     low_amp_reg     <= pwdata[AMP_BITS-1:0];
                REG_HIGH_AMP:    high_amp_reg    <= pwdata[AMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SAMPLE_RATE: prdata = 32'(sample_rate_reg);
            REG_DURATION:    prdata = 32'(duration_reg);
            REG_LOW_AMP:     prdata = 32'(low_amp_reg);
            REG_HIGH_AMP:    prdata = 32'(high_amp_reg);
            default:         prdata = '0;
        endcase
    end

    dtg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_cmd   (item.cmd),
        .status     (dp_status),
        .cmd        (dp_cmd)
    );

    dtg_datapath #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .digit        (item.digit),
        .sample_rate  (sample_rate_reg),
        .duration     (duration_reg),
        .low_amp      (low_amp_reg),
        .high_amp     (high_amp_reg),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // A set-tone beat never produces a result beat right behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.cmd == CMD_SET_TONE |=> !$rose(result_valid))
        else $error("result raised by a set-tone beat");

    // The sequencer finishes a tick only into a free result register
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.finish |-> dp_status.out_free)
        else $error("finish step while result register is occupied");

    // A result appears only out of a finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(dp_cmd.finish))
        else $error("result valid without a finish step");

endmodule
